// ===== hdl/arc_pkg.sv =====
// Package for the adaptive replacement cache unit: request and response
// structs, sizing constants, list codes and sequencer states.
// Used by arc_cache_replacement_unit; depends on nothing.
package arc_pkg;

	localparam int ENTRIES  = 16;
	localparam int KEY_BITS = 32;
	localparam int KEY_W    = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int IW       = $clog2(ENTRIES);
	localparam int PW       = 5;
	localparam logic [PW-1:0] NIL = 5'd31;
	localparam int EVENT_LIMIT = 32;
	localparam logic [15:0] CAP_RESET = 16'd64;
	localparam int DIV_STEPS = 17;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_PEEK   = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] LST_RECENT   = 2'd0;
	localparam logic [1:0] LST_FREQUENT = 2'd1;
	localparam logic [1:0] LST_RGHOST   = 2'd2;
	localparam logic [1:0] LST_FGHOST   = 2'd3;

	localparam logic [2:0] ST_FREE   = 3'd0;
	localparam logic [2:0] ST_RECENT = 3'd1;
	localparam logic [2:0] ST_FREQ   = 3'd2;
	localparam logic [2:0] ST_RGHOST = 3'd3;

	localparam logic [1:0] RES_FINAL   = 2'd0;
	localparam logic [1:0] RES_EVICT   = 2'd1;
	localparam logic [1:0] RES_DESTROY = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] key;
		logic [7:0]  item_size;
	} req_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [31:0] event_key;
		logic        found;
		logic        is_new;
		logic        resident;
		logic        refused;
		logic [16:0] total_size;
		logic [15:0] target_now;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_DISPATCH, S_CLEAR, S_REMOVE, S_DIV, S_ADAPT,
		S_UNLINK_HIT, S_BAL1, S_BAL1_PUSH, S_BAL2, S_WRITE, S_PUSH, S_FINAL
	} state_t;

	function automatic logic [1:0] clear_list(input logic [1:0] step);
		case (step)
			2'd0:    clear_list = LST_RGHOST;
			2'd1:    clear_list = LST_RECENT;
			2'd2:    clear_list = LST_FREQUENT;
			default: clear_list = LST_FGHOST;
		endcase
	endfunction

endpackage

// ===== hdl/arc_cache_replacement_unit.sv =====
// Top level of the adaptive replacement cache unit: sequencer, entry table,
// list links, shared restoring divider and the configuration port.
// Depends on arc_pkg.
// A ghost hit runs the divider and the target update before the entry is relinked.
// One request is taken at a time; a stalled response holds the sequencer. Reset
// empties all lists at once and sets the target to half the reset capacity.
module arc_cache_replacement_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  arc_pkg::req_t     req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output arc_pkg::rsp_t     rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import arc_pkg::*;

	state_t state_q, state_d;

	logic [15:0]      cap_q;
	logic [15:0]      target_q;
	logic [1:0]       cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [7:0]       isz_q;
	logic [PW-1:0]    idx_q;
	logic [PW-1:0]    hit_q;
	logic [PW-1:0]    free_q;
	logic [IW-1:0]    tgt_q;
	logic [IW-1:0]    t_q;
	logic [1:0]       pl_q;
	logic [1:0]       hl_q;
	logic [7:0]       bsz_q;
	logic             bal_first_q;
	logic             ghost_rg_q;
	logic [1:0]       clr_q;
	logic [5:0]       cnt_q;
	logic             found_q, is_new_q, resident_q, refused_q;
	logic [16:0]      num_q, den_q, rem_q, quo_q;
	logic [4:0]       div_cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [KEY_W-1:0] ekey_q  [ENTRIES];
	logic [7:0]       esize_q [ENTRIES];
	logic [2:0]       elist_q [ENTRIES];
	logic [PW-1:0]    prev_q  [ENTRIES];
	logic [PW-1:0]    next_q  [ENTRIES];
	logic [PW-1:0]    head_q  [4];
	logic [PW-1:0]    tail_q  [4];
	logic [16:0]      lsize_q [4];

	logic          do_ul, do_pu, emit_ev, emit_fin, slot_free;
	logic [IW-1:0] ul_i, pu_i;
	logic [1:0]    pu_l, ev_res;
	logic [IW-1:0] ev_i;
	logic [PW-1:0] ul_p, ul_n, pu_h;
	logic [1:0]    ul_l;
	logic [17:0]   res_sum;
	logic [17:0]   div_sh;
	logic          div_ge;
	logic [1:0]    clr_l;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == 1'b0) ? {16'd0, cap_q} : 32'd0;

	assign ul_p    = prev_q[ul_i];
	assign ul_n    = next_q[ul_i];
	assign ul_l    = 2'(elist_q[ul_i] - 3'd1);
	assign pu_h    = head_q[pu_l];
	assign res_sum = 18'(lsize_q[LST_RECENT]) + 18'(lsize_q[LST_FREQUENT]) + 18'(bsz_q);
	assign div_sh  = {rem_q, num_q[16]};
	assign div_ge  = (div_sh >= {1'b0, den_q});
	assign clr_l   = clear_list(clr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic [PW-1:0] tl;
		state_d  = state_q;
		do_ul    = 1'b0;
		do_pu    = 1'b0;
		ul_i     = tgt_q;
		pu_i     = tgt_q;
		pu_l     = hl_q;
		emit_ev  = 1'b0;
		emit_fin = 1'b0;
		ev_res   = RES_DESTROY;
		ev_i     = tgt_q;
		tl       = NIL;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_SEARCH;
			end
			S_SEARCH: begin
				if (idx_q == PW'(ENTRIES - 1)) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (cmd_q == CMD_CLEAR) begin
					state_d = S_CLEAR;
				end else if (cmd_q == CMD_REMOVE) begin
					state_d = (hit_q < PW'(ENTRIES)) ? S_REMOVE : S_FINAL;
				end else if (hit_q < PW'(ENTRIES)) begin
					if (elist_q[hit_q[IW-1:0]] == ST_RECENT ||
					    elist_q[hit_q[IW-1:0]] == ST_FREQ) begin
						state_d = S_UNLINK_HIT;
					end else begin
						state_d = S_DIV;
					end
				end else if (cmd_q == CMD_LOOKUP && free_q < PW'(ENTRIES)) begin
					state_d = S_BAL1;
				end else begin
					state_d = S_FINAL;
				end
			end
			S_CLEAR: begin
				tl = head_q[clr_l];
				if (tl < PW'(ENTRIES)) begin
					if (slot_free) begin
						do_ul   = 1'b1;
						ul_i    = tl[IW-1:0];
						emit_ev = 1'b1;
						ev_i    = tl[IW-1:0];
					end
				end else if (clr_q == 2'd3) begin
					state_d = S_FINAL;
				end
			end
			S_REMOVE: begin
				if (slot_free) begin
					do_ul   = 1'b1;
					emit_ev = 1'b1;
					state_d = S_FINAL;
				end
			end
			S_DIV: begin
				if (div_cnt_q == 5'(DIV_STEPS - 1)) state_d = S_ADAPT;
			end
			S_ADAPT: begin
				state_d = S_UNLINK_HIT;
			end
			S_UNLINK_HIT: begin
				do_ul   = 1'b1;
				state_d = S_BAL1;
			end
			S_BAL1: begin
				state_d = S_BAL2;
				if (res_sum > 18'(cap_q)) begin
					if (lsize_q[LST_RECENT] > 17'(target_q) &&
					    tail_q[LST_RECENT] < PW'(ENTRIES)) begin
						do_ul   = 1'b1;
						ul_i    = tail_q[LST_RECENT][IW-1:0];
						state_d = S_BAL1_PUSH;
					end else if (lsize_q[LST_FREQUENT] != 17'd0 &&
					             tail_q[LST_FREQUENT] < PW'(ENTRIES)) begin
						do_ul   = 1'b1;
						ul_i    = tail_q[LST_FREQUENT][IW-1:0];
						state_d = S_BAL1_PUSH;
					end
				end
			end
			S_BAL1_PUSH: begin
				if (slot_free) begin
					do_pu   = 1'b1;
					pu_i    = t_q;
					pu_l    = pl_q;
					emit_ev = 1'b1;
					ev_res  = RES_EVICT;
					ev_i    = t_q;
					state_d = S_BAL1;
				end
			end
			S_BAL2: begin
				if (18'(lsize_q[LST_RGHOST]) + 18'(lsize_q[LST_FGHOST]) > 18'(cap_q) &&
				    ((lsize_q[LST_FGHOST] > 17'(target_q) &&
				      tail_q[LST_FGHOST] < PW'(ENTRIES)) ||
				     (lsize_q[LST_RGHOST] != 17'd0 &&
				      tail_q[LST_RGHOST] < PW'(ENTRIES)))) begin
					if (lsize_q[LST_FGHOST] > 17'(target_q) &&
					    tail_q[LST_FGHOST] < PW'(ENTRIES)) begin
						tl = tail_q[LST_FGHOST];
					end else begin
						tl = tail_q[LST_RGHOST];
					end
					if (slot_free) begin
						do_ul   = 1'b1;
						ul_i    = tl[IW-1:0];
						emit_ev = 1'b1;
						ev_i    = tl[IW-1:0];
					end
				end else begin
					state_d = bal_first_q ? S_WRITE : S_PUSH;
				end
			end
			S_WRITE: begin
				state_d = S_BAL1;
			end
			S_PUSH: begin
				do_pu   = 1'b1;
				state_d = S_FINAL;
			end
			S_FINAL: begin
				if (slot_free) begin
					emit_fin = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers of the sequencer and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [16:0] q1;
		logic [17:0] up;
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			target_q    <= CAP_RESET >> 1;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			hit_q       <= NIL;
			free_q      <= NIL;
			clr_q       <= '0;
			cnt_q       <= '0;
			div_cnt_q   <= '0;
			bal_first_q <= 1'b0;
			found_q     <= 1'b0;
			is_new_q    <= 1'b0;
			resident_q  <= 1'b0;
			refused_q   <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr[2] == 1'b0) cap_q <= pwdata[15:0];
			case (state_q)
				S_IDLE: begin
					idx_q       <= '0;
					hit_q       <= NIL;
					free_q      <= NIL;
					clr_q       <= '0;
					cnt_q       <= '0;
					div_cnt_q   <= '0;
					found_q     <= 1'b0;
					is_new_q    <= 1'b0;
					resident_q  <= 1'b0;
					refused_q   <= 1'b0;
					bal_first_q <= 1'b0;
				end
				S_SEARCH: begin
					idx_q <= idx_q + PW'(1);
					if (hit_q == NIL && elist_q[idx_q[IW-1:0]] != ST_FREE &&
					    ekey_q[idx_q[IW-1:0]] == key_q) hit_q <= idx_q;
					if (free_q == NIL && elist_q[idx_q[IW-1:0]] == ST_FREE)
						free_q <= idx_q;
				end
				S_DISPATCH: begin
					if (cmd_q != CMD_CLEAR && hit_q < PW'(ENTRIES)) found_q <= 1'b1;
					if ((cmd_q == CMD_LOOKUP || cmd_q == CMD_PEEK) &&
					    hit_q < PW'(ENTRIES)) resident_q <= 1'b1;
					if (cmd_q == CMD_LOOKUP && hit_q >= PW'(ENTRIES)) begin
						if (free_q < PW'(ENTRIES)) begin
							bal_first_q <= 1'b1;
							is_new_q    <= 1'b1;
							resident_q  <= 1'b1;
						end else begin
							refused_q <= 1'b1;
						end
					end
				end
				S_CLEAR: begin
					if (head_q[clr_l] >= PW'(ENTRIES) && clr_q != 2'd3)
						clr_q <= clr_q + 2'd1;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
				end
				S_ADAPT: begin
					q1 = (den_q == 17'd0 || quo_q == 17'd0) ? 17'd1 : quo_q;
					up = 18'(q1) + 18'(target_q);
					if (ghost_rg_q) begin
						target_q <= (up > 18'(cap_q)) ? cap_q : up[15:0];
					end else begin
						target_q <= (q1 > 17'(target_q)) ? 16'd0 :
						            16'(17'(target_q) - q1);
					end
				end
				S_BAL2: begin
					if (state_d == S_WRITE) bal_first_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (emit_ev && cnt_q < 6'(EVENT_LIMIT)) cnt_q <= cnt_q + 6'd1;
			if ((emit_ev && cnt_q < 6'(EVENT_LIMIT)) || emit_fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request fields, divider and response payload.
	always_ff @(posedge clk) begin
		rsp_t rsp_n;
		if (state_q == S_IDLE && req_valid) begin
			cmd_q <= req.cmd;
			key_q <= req.key[KEY_W-1:0];
			isz_q <= req.item_size;
		end
		case (state_q)
			S_DISPATCH: begin
				tgt_q      <= (hit_q < PW'(ENTRIES)) ? hit_q[IW-1:0] : free_q[IW-1:0];
				hl_q       <= (hit_q < PW'(ENTRIES)) ? LST_FREQUENT : LST_RECENT;
				ghost_rg_q <= (elist_q[hit_q[IW-1:0]] == ST_RGHOST);
				bsz_q      <= '0;
				rem_q      <= '0;
				quo_q      <= '0;
				if (elist_q[hit_q[IW-1:0]] == ST_RGHOST) begin
					num_q <= lsize_q[LST_FGHOST];
					den_q <= lsize_q[LST_RGHOST];
				end else begin
					num_q <= lsize_q[LST_RGHOST];
					den_q <= lsize_q[LST_FGHOST];
				end
			end
			S_DIV: begin
				rem_q <= div_ge ? 17'(div_sh - {1'b0, den_q}) : div_sh[16:0];
				quo_q <= {quo_q[15:0], div_ge};
				num_q <= {num_q[15:0], 1'b0};
			end
			S_ADAPT: begin
				bsz_q <= esize_q[tgt_q];
			end
			S_BAL1: begin
				t_q  <= ul_i;
				pl_q <= (lsize_q[LST_RECENT] > 17'(target_q) &&
				         tail_q[LST_RECENT] < PW'(ENTRIES)) ? LST_RGHOST : LST_FGHOST;
			end
			S_WRITE: begin
				bsz_q <= isz_q;
			end
			default: begin
			end
		endcase
		rsp_n = '0;
		if (emit_ev && cnt_q < 6'(EVENT_LIMIT)) begin
			rsp_n.event_res = ev_res;
			rsp_n.event_key = 32'(ekey_q[ev_i]);
			rsp_q <= rsp_n;
		end else if (emit_fin) begin
			rsp_n.event_res  = RES_FINAL;
			rsp_n.found      = found_q;
			rsp_n.is_new     = is_new_q;
			rsp_n.resident   = resident_q;
			rsp_n.refused    = refused_q;
			rsp_n.total_size = lsize_q[0] + lsize_q[1] + lsize_q[2] + lsize_q[3];
			rsp_n.target_now = target_q;
			rsp_n.last       = 1'b1;
			rsp_q <= rsp_n;
		end
	end

	// Entry payload and list links.
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			ekey_q[tgt_q]  <= key_q;
			esize_q[tgt_q] <= isz_q;
		end
		if (do_ul) begin
			if (ul_p < PW'(ENTRIES)) next_q[ul_p[IW-1:0]] <= ul_n;
			if (ul_n < PW'(ENTRIES)) prev_q[ul_n[IW-1:0]] <= ul_p;
		end
		if (do_pu) begin
			prev_q[pu_i] <= NIL;
			next_q[pu_i] <= pu_h;
			if (pu_h < PW'(ENTRIES)) prev_q[pu_h[IW-1:0]] <= PW'(pu_i);
		end
	end

	// List membership, heads, tails and size totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < ENTRIES; e++) elist_q[e] <= ST_FREE;
			for (int l = 0; l < 4; l++) begin
				head_q[l]  <= NIL;
				tail_q[l]  <= NIL;
				lsize_q[l] <= '0;
			end
		end else begin
			if (do_ul) begin
				if (ul_p >= PW'(ENTRIES)) head_q[ul_l] <= ul_n;
				if (ul_n >= PW'(ENTRIES)) tail_q[ul_l] <= ul_p;
				lsize_q[ul_l] <= lsize_q[ul_l] - 17'(esize_q[ul_i]);
				elist_q[ul_i] <= ST_FREE;
			end
			if (do_pu) begin
				head_q[pu_l] <= PW'(pu_i);
				if (pu_h >= PW'(ENTRIES)) tail_q[pu_l] <= PW'(pu_i);
				lsize_q[pu_l] <= lsize_q[pu_l] + 17'(esize_q[pu_i]);
				elist_q[pu_i] <= 3'(pu_l) + 3'd1;
			end
		end
	end

endmodule

// ===== sim/arc_cache_replacement_unit_tb.sv =====
// Testbench for arc_cache_replacement_unit: directed table, runs at capacity
// 1 and 65535, then random requests, each response checked against an in-bench
// model of the replacement policy. Depends on arc_pkg and the unit's RTL.
`timescale 1ns / 100ps

module arc_cache_replacement_unit_tb;
	import arc_pkg::*;

	localparam int NREQ = 400;
	localparam int MAX_CYCLES = 1000000;
	localparam logic [2:0] ADDR_CAPACITY = 3'd0;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	arc_cache_replacement_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Policy model state.
	logic [31:0] m_key [ENTRIES];
	logic [7:0]  m_size [ENTRIES];
	logic [2:0]  m_where [ENTRIES];
	logic [4:0]  m_prev [ENTRIES];
	logic [4:0]  m_next [ENTRIES];
	logic [4:0]  m_head [4];
	logic [4:0]  m_tail [4];
	logic [16:0] m_lsize [4];
	logic [15:0] m_target;
	logic [15:0] m_cap;

	rsp_t pending_rsp [$];
	int errors;
	int n_rsp;
	int n_evict;
	int n_destroy;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("** arc_cache_replacement_unit: FAILED **");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int clear_order(input int s);
		return int'(clear_list(2'(s)));
	endfunction

	task automatic model_reset();
		for (int i = 0; i < ENTRIES; i++) begin
			m_where[i] = ST_FREE;
			m_key[i] = '0;
			m_size[i] = '0;
			m_prev[i] = NIL;
			m_next[i] = NIL;
		end
		for (int l = 0; l < 4; l++) begin
			m_head[l] = NIL;
			m_tail[l] = NIL;
			m_lsize[l] = '0;
		end
		m_cap = CAP_RESET;
		m_target = CAP_RESET >> 1;
	endtask

	task automatic list_unlink(input int i);
		int l;
		logic [4:0] p;
		logic [4:0] n;
		l = m_where[i] - 1;
		p = m_prev[i];
		n = m_next[i];
		if (p < ENTRIES) m_next[p] = n; else m_head[l] = n;
		if (n < ENTRIES) m_prev[n] = p; else m_tail[l] = p;
		m_lsize[l] = m_lsize[l] - m_size[i];
		m_where[i] = ST_FREE;
	endtask

	task automatic list_push(input int i, input int l);
		logic [4:0] h;
		h = m_head[l];
		m_prev[i] = NIL;
		m_next[i] = h;
		if (h < ENTRIES) m_prev[h] = i[4:0]; else m_tail[l] = i[4:0];
		m_head[l] = i[4:0];
		m_lsize[l] = m_lsize[l] + m_size[i];
		m_where[i] = 3'(l + 1);
	endtask

	task automatic note_event(input logic [1:0] kind, input logic [31:0] k);
		rsp_t r;
		r = '0;
		r.event_res = kind;
		r.event_key = k;
		pending_rsp.push_back(r);
	endtask

	task automatic destroy(input int i);
		list_unlink(i);
		note_event(RES_DESTROY, m_key[i]);
	endtask

	task automatic rebalance(input int sz);
		int t;
		while (int'(m_lsize[LST_RECENT]) + int'(m_lsize[LST_FREQUENT]) + sz > int'(m_cap)) begin
			if (m_lsize[LST_RECENT] > m_target && m_tail[LST_RECENT] < ENTRIES) begin
				t = m_tail[LST_RECENT];
				list_unlink(t);
				list_push(t, LST_RGHOST);
				note_event(RES_EVICT, m_key[t]);
			end else if (m_lsize[LST_FREQUENT] > 0 && m_tail[LST_FREQUENT] < ENTRIES) begin
				t = m_tail[LST_FREQUENT];
				list_unlink(t);
				list_push(t, LST_FGHOST);
				note_event(RES_EVICT, m_key[t]);
			end else break;
		end
		while (int'(m_lsize[LST_RGHOST]) + int'(m_lsize[LST_FGHOST]) > int'(m_cap)) begin
			if (m_lsize[LST_FGHOST] > m_target && m_tail[LST_FGHOST] < ENTRIES)
				destroy(m_tail[LST_FGHOST]);
			else if (m_lsize[LST_RGHOST] > 0 && m_tail[LST_RGHOST] < ENTRIES)
				destroy(m_tail[LST_RGHOST]);
			else break;
		end
	endtask

	task automatic predict_request(input req_t q);
		int hit;
		int f;
		int st;
		int rg;
		int fg;
		int qt;
		rsp_t fin;
		hit = -1;
		f = -1;
		fin = '0;
		fin.last = 1'b1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && m_where[i] != ST_FREE && m_key[i] == q.key) hit = i;
		if (q.cmd == CMD_CLEAR) begin
			for (int s = 0; s < 4; s++)
				while (m_head[clear_order(s)] < ENTRIES) destroy(m_head[clear_order(s)]);
		end else if (q.cmd == CMD_REMOVE) begin
			if (hit >= 0) begin
				fin.found = 1'b1;
				destroy(hit);
			end
		end else if (hit >= 0) begin
			st = m_where[hit];
			fin.found = 1'b1;
			if (st == ST_RECENT || st == ST_FREQ) begin
				list_unlink(hit);
				rebalance(0);
			end else begin
				rg = m_lsize[LST_RGHOST];
				fg = m_lsize[LST_FGHOST];
				if (st == ST_RGHOST) begin
					qt = (rg != 0) ? fg / rg : 0;
					if (qt < 1) qt = 1;
					qt = qt + m_target;
					m_target = (qt > m_cap) ? m_cap : 16'(qt);
				end else begin
					qt = (fg != 0) ? rg / fg : 0;
					if (qt < 1) qt = 1;
					m_target = (qt > m_target) ? 16'd0 : 16'(m_target - qt);
				end
				list_unlink(hit);
				rebalance(m_size[hit]);
			end
			list_push(hit, LST_FREQUENT);
			fin.resident = 1'b1;
		end else if (q.cmd == CMD_LOOKUP) begin
			for (int i = 0; i < ENTRIES; i++)
				if (f < 0 && m_where[i] == ST_FREE) f = i;
			if (f < 0) fin.refused = 1'b1;
			else begin
				rebalance(0);
				m_key[f] = q.key;
				m_size[f] = q.item_size;
				rebalance(q.item_size);
				list_push(f, LST_RECENT);
				fin.is_new = 1'b1;
				fin.resident = 1'b1;
			end
		end
		fin.total_size = m_lsize[0] + m_lsize[1] + m_lsize[2] + m_lsize[3];
		fin.target_now = m_target;
		pending_rsp.push_back(fin);
	endtask

	// Response side: random stall, compare against the oldest expectation.
	initial begin
		int g;
		rsp_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			if (g != 0) begin
				rsp_stall = 1'b1;
				repeat (g) @(negedge clk);
			end
			rsp_stall = 1'b0;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response %p", $time, rsp);
				errors++;
			end else begin
				if (rsp !== pending_rsp[0]) begin
					$display("%0t: mismatch expected %p actual %p", $time,
						pending_rsp[0], rsp);
					errors++;
				end
				if (rsp.event_res == RES_EVICT) n_evict++;
				if (rsp.event_res == RES_DESTROY) n_destroy++;
				n_rsp++;
				void'(pending_rsp.pop_front());
			end
		end
	end

	task automatic send(input req_t q);
		int g;
		g = gap_len();
		repeat (g + 1) @(negedge clk);
		req_valid <= 1'b1;
		req <= q;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_request(q);
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic write_capacity(input logic [15:0] c);
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_CAPACITY;
		pwdata <= {16'd0, c};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		m_cap = c;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic req_t mk(input logic [1:0] c, input logic [31:0] k,
			input logic [7:0] s);
		req_t q;
		q.cmd = c;
		q.key = k;
		q.item_size = s;
		return q;
	endfunction

	req_t directed [24];
	rsp_t directed_final [24];
	bit directed_known [24];
	logic [31:0] keypool [8];

	initial begin
		req_t q;
		int r;
		errors = 0;
		cycles = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		model_reset();

		directed[0] = mk(CMD_PEEK, 32'hFFFF_FFFF, 8'hFF);
		directed[1] = mk(CMD_REMOVE, 32'h0, 8'h1);
		directed[2] = mk(CMD_CLEAR, 32'h1234, 8'h0);
		directed[3] = mk(CMD_LOOKUP, 32'h0, 8'd1);
		directed[4] = mk(CMD_LOOKUP, 32'hFFFF_FFFF, 8'd255);
		directed[5] = mk(CMD_LOOKUP, 32'hA5A5_5A5A, 8'd0);
		directed[6] = mk(CMD_LOOKUP, 32'h0, 8'd9);
		for (int i = 7; i < 21; i++)
			directed[i] = mk(CMD_LOOKUP, 32'h100 + i, 8'(3 * i));
		directed[21] = mk(CMD_LOOKUP, 32'hFFFF_FFFF, 8'd2);
		directed[22] = mk(CMD_REMOVE, 32'h10A, 8'd1);
		directed[23] = mk(CMD_CLEAR, 32'h0, 8'd0);
		for (int i = 0; i < 24; i++) directed_known[i] = 1'b0;
		directed_final[0] = '{event_res: RES_FINAL, target_now: 16'd32, last: 1'b1,
			default: '0};
		directed_known[0] = 1'b1;
		directed_final[1] = directed_final[0];
		directed_known[1] = 1'b1;
		directed_final[3] = '{event_res: RES_FINAL, is_new: 1'b1, resident: 1'b1,
			total_size: 17'd1, target_now: 16'd32, last: 1'b1, default: '0};
		directed_known[3] = 1'b1;

		@(negedge clk);
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < 24; i++) begin
			send(directed[i]);
			if (directed_known[i] && pending_rsp[$] !== directed_final[i]) begin
				$display("%0t: directed row %0d expected %p model %p", $time, i,
					directed_final[i], pending_rsp[$]);
				errors++;
			end
		end

		write_capacity(16'd1);
		for (int i = 0; i < 20; i++) send(mk(2'(i % 2 ? CMD_PEEK : CMD_LOOKUP),
			32'(i % 5), 8'($urandom_range(0, 2))));
		write_capacity(16'd65535);
		for (int i = 0; i < 18; i++) send(mk(CMD_LOOKUP, 32'(i), 8'd255));

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_capacity(16'd64);
				1: write_capacity(16'd200);
				2: write_capacity(16'd16);
				3: write_capacity(16'($urandom_range(1, 65535)));
				default: write_capacity(16'd100);
			endcase
			for (int k = 0; k < 8; k++) keypool[k] = $urandom();
			for (int n = 0; n < NREQ / 5; n++) begin
				r = $urandom_range(0, 99);
				q.key = (r % 10 == 0) ? $urandom() : keypool[$urandom_range(0, 7)];
				if (ph == 4 && r % 7 == 0) q.key = 32'(r);
				q.item_size = (r < 8) ? 8'($urandom()) : 8'($urandom_range(0, 40));
				if (r < 65) q.cmd = CMD_LOOKUP;
				else if (r < 85) q.cmd = CMD_PEEK;
				else if (r < 97) q.cmd = CMD_REMOVE;
				else q.cmd = CMD_CLEAR;
				send(q);
			end
		end

		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("Covered %0d responses: %0d evictions, %0d destructions,", n_rsp,
			n_evict, n_destroy);
		$display("over capacities from 1 to 65535 with random stalls on both sides.");
		if (errors == 0) begin
			$display("** arc_cache_replacement_unit: PASSED **");
		end else begin
			$display("** arc_cache_replacement_unit: FAILED **");
		end
		$finish;
	end

endmodule
